### hw/rtl/gbfs_pkg.sv
// shared types and codes for the grid breadth-first distance map
// no dependencies; used by gbfs_nbr and grid_bfs_distance_map
package gbfs_pkg;

    localparam int DIST_W      = 15;
    localparam int CFG_W       = 7;
    localparam int CFG_FLOOR_W = 3;
    localparam int CFG_IDX_W   = 2;

    // transaction op codes
    typedef logic [1:0] t_op;
    localparam t_op OP_WRITE  = 2'd0;
    localparam t_op OP_SEARCH = 2'd1;
    localparam t_op OP_READ   = 2'd2;

    // reply kinds
    localparam logic KIND_SEARCH = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef logic signed [DIST_W-1:0] t_dist;
    localparam t_dist DIST_NONE = -15'sd1;

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_HEIGHT = 2'd1;
    localparam t_cfg_idx CFG_FLOORS = 2'd2;

    localparam logic [CFG_W-1:0]       RST_WIDTH  = 7'd64;
    localparam logic [CFG_W-1:0]       RST_HEIGHT = 7'd64;
    localparam logic [CFG_FLOOR_W-1:0] RST_FLOORS = 3'd4;

    // cell flags
    typedef logic [2:0] t_flags;
    localparam int     FLAG_WALL   = 0;
    localparam int     FLAG_UP     = 1;
    localparam int     FLAG_DN     = 2;
    localparam t_flags FLAGS_RESET = 3'b001;

    // neighbour directions
    typedef logic [2:0] t_dir;
    localparam t_dir NB_EAST  = 3'd0;
    localparam t_dir NB_WEST  = 3'd1;
    localparam t_dir NB_SOUTH = 3'd2;
    localparam t_dir NB_NORTH = 3'd3;
    localparam t_dir NB_UP    = 3'd4;
    localparam t_dir NB_DOWN  = 3'd5;
    localparam t_dir NB_SELF  = 3'd6;

    typedef struct packed {
        t_dir dir;
        logic up;
        logic dn;
    } t_nbr_sel;

endpackage

### hw/rtl/gbfs_nbr.sv
// neighbour generator: steps one cell in a direction and checks it lies in the grid in use
// depends on gbfs_pkg
module gbfs_nbr #(
    parameter int MAX_COLS   = 64,
    parameter int MAX_ROWS   = 64,
    parameter int MAX_FLOORS = 4,
    localparam int CW = $clog2(MAX_COLS),
    localparam int RW = $clog2(MAX_ROWS),
    localparam int FW = (MAX_FLOORS > 1) ? $clog2(MAX_FLOORS) : 1,
    localparam int CX = (CW + 1 > 7) ? CW + 1 : 7,
    localparam int RX = (RW + 1 > 7) ? RW + 1 : 7,
    localparam int FX = (FW + 1 > 3) ? FW + 1 : 3
) (
    input  gbfs_pkg::t_nbr_sel                    i_sel,
    input  logic [FX-1:0]                         i_f,
    input  logic [RX-1:0]                         i_r,
    input  logic [CX-1:0]                         i_c,
    input  logic [gbfs_pkg::CFG_W-1:0]            i_cfg_w,
    input  logic [gbfs_pkg::CFG_W-1:0]            i_cfg_h,
    input  logic [gbfs_pkg::CFG_FLOOR_W-1:0]      i_cfg_f,
    output logic                                  o_ok,
    output logic [FW-1:0]                         o_f,
    output logic [RW-1:0]                         o_r,
    output logic [CW-1:0]                         o_c
);
    import gbfs_pkg::*;

    logic [CX-1:0] eff_w;
    logic [RX-1:0] eff_h;
    logic [FX-1:0] eff_f;
    logic [CX-1:0] nc;
    logic [RX-1:0] nr;
    logic [FX-1:0] nf;
    logic          step_ok;

    // registers above the physical size act as the maximum
    assign eff_w = (CX'(i_cfg_w) > CX'(MAX_COLS))   ? CX'(MAX_COLS)   : CX'(i_cfg_w);
    assign eff_h = (RX'(i_cfg_h) > RX'(MAX_ROWS))   ? RX'(MAX_ROWS)   : RX'(i_cfg_h);
    assign eff_f = (FX'(i_cfg_f) > FX'(MAX_FLOORS)) ? FX'(MAX_FLOORS) : FX'(i_cfg_f);

    always_comb begin
        nc      = i_c;
        nr      = i_r;
        nf      = i_f;
        step_ok = 1'b1;
        unique case (i_sel.dir)
            NB_EAST: begin
                nc = i_c + CX'(1);
            end
            NB_WEST: begin
                step_ok = (i_c != '0);
                nc      = i_c - CX'(1);
            end
            NB_SOUTH: begin
                nr = i_r + RX'(1);
            end
            NB_NORTH: begin
                step_ok = (i_r != '0);
                nr      = i_r - RX'(1);
            end
            NB_UP: begin
                step_ok = i_sel.up;
                nf      = i_f + FX'(1);
            end
            NB_DOWN: begin
                step_ok = i_sel.dn && (i_f != '0);
                nf      = i_f - FX'(1);
            end
            NB_SELF: begin
                step_ok = 1'b1;
            end
            default: begin
                step_ok = 1'b0;
            end
        endcase
    end

    assign o_ok = step_ok && (nc < eff_w) && (nr < eff_h) && (nf < eff_f);
    assign o_f  = nf[FW-1:0];
    assign o_r  = nr[RW-1:0];
    assign o_c  = nc[CW-1:0];

endmodule

### hw/rtl/grid_bfs_distance_map.sv
// grid breadth-first distance map: cell flag store, distance store and frontier queue
// depends on gbfs_pkg and gbfs_nbr
//
// channel   | signals                                          | handshake
// ----------+--------------------------------------------------+------------------------------
// command   | i_op, i_cell_floor/col/row, i_is_wall,            | start high while busy low
//           | i_has_stair_up, i_has_stair_down                  |
// reply     | o_reply_kind, o_distance                          | o_valid for one cycle, no stall
// config    | i_cfg_we, i_cfg_idx, i_cfg_wdata                  | write on any edge with i_cfg_we
//
// cell writes and distance reads stream back to back; a read answer passes the grid
// read register and then the reply register before it shows on o_valid
// a search first sweeps the distance lane of the grid memory, one cell per cycle,
// then checks the start, then for each reached cell pops the queue, reads the cell,
// makes six neighbour reads and drains, plus one final pop; the single grid memory
// port pair keeps the neighbour reads one at a time
// after reset the same sweep writes every cell to wall with no distance while busy
// stays high; configuration writes are taken at all times
// busy is high for the whole search and reset sweep; the receiver cannot hold off replies
module grid_bfs_distance_map #(
    parameter int MAX_COLS   = 64,
    parameter int MAX_ROWS   = 64,
    parameter int MAX_FLOORS = 4,
    localparam int CW         = $clog2(MAX_COLS),
    localparam int RW         = $clog2(MAX_ROWS),
    localparam int FW         = (MAX_FLOORS > 1) ? $clog2(MAX_FLOORS) : 1,
    localparam int CX         = (CW + 1 > 7) ? CW + 1 : 7,
    localparam int RX         = (RW + 1 > 7) ? RW + 1 : 7,
    localparam int FX         = (FW + 1 > 3) ? FW + 1 : 3,
    localparam int CELL_TOTAL = MAX_FLOORS * MAX_ROWS * MAX_COLS,
    localparam int AW         = $clog2(CELL_TOTAL),
    localparam int DW         = AW,
    localparam int QW         = FW + RW + CW,
    localparam int GE         = DW + 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  gbfs_pkg::t_op                    i_op,
    input  logic [1:0]                       i_cell_floor,
    input  logic [5:0]                       i_cell_col,
    input  logic [5:0]                       i_cell_row,
    input  logic                             i_is_wall,
    input  logic                             i_has_stair_up,
    input  logic                             i_has_stair_down,
    input  logic                             i_cfg_we,
    input  gbfs_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [gbfs_pkg::CFG_W-1:0]       i_cfg_wdata,
    output logic                             o_valid,
    output logic                             o_reply_kind,
    output gbfs_pkg::t_dist                  o_distance
);
    import gbfs_pkg::*;

    // sequencer states
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_SWEEP     = 4'd1;
    localparam logic [3:0] ST_START     = 4'd2;
    localparam logic [3:0] ST_START_CHK = 4'd3;
    localparam logic [3:0] ST_POP       = 4'd4;
    localparam logic [3:0] ST_CUR       = 4'd5;
    localparam logic [3:0] ST_FLAGS     = 4'd6;
    localparam logic [3:0] ST_NBR       = 4'd7;
    localparam logic [3:0] ST_DRAIN     = 4'd8;

    // grid entry layout: {flags, visited, distance}
    localparam int VIS_BIT  = DW;
    localparam int FLAG_LO  = DW + 1;
    localparam int WALL_BIT = FLAG_LO + FLAG_WALL;
    localparam int UP_BIT   = FLAG_LO + FLAG_UP;
    localparam int DN_BIT   = FLAG_LO + FLAG_DN;

    function automatic logic [AW-1:0] f_addr(input logic [FW-1:0] f,
                                             input logic [RW-1:0] r,
                                             input logic [CW-1:0] c);
        f_addr = (AW'(f) * AW'(MAX_ROWS) + AW'(r)) * AW'(MAX_COLS) + AW'(c);
    endfunction

    // memories
    logic [GE-1:0] grid_mem  [CELL_TOTAL];
    logic [QW-1:0] queue_mem [CELL_TOTAL];

    // configuration
    logic [CFG_W-1:0]       r_cfg_w;
    logic [CFG_W-1:0]       r_cfg_h;
    logic [CFG_FLOOR_W-1:0] r_cfg_f;

    // control state
    logic [3:0]  r_state,  n_state;
    logic [AW-1:0] r_sweep, n_sweep;
    logic        r_sweep_cells, n_sweep_cells;
    logic [AW:0] r_head,   n_head;
    logic [AW:0] r_tail,   n_tail;
    t_dir        r_k,      n_k;
    logic        r_p_valid, n_p_valid;
    logic        r_rd_pend, n_rd_pend;
    logic        r_out_valid, n_out_valid;

    // payload
    logic          r_out_kind, n_out_kind;
    t_dist         r_out_dist, n_out_dist;
    logic          r_rd_phys;
    logic          r_st_ok;
    logic [AW-1:0] r_st_addr;
    logic [QW-1:0] r_st_entry;
    logic [FW-1:0] r_cur_f;
    logic [RW-1:0] r_cur_r;
    logic [CW-1:0] r_cur_c;
    logic          r_cur_up;
    logic          r_cur_dn;
    logic [DW-1:0] r_nd;
    logic [AW-1:0] r_p_addr;
    logic [QW-1:0] r_p_entry;
    logic [GE-1:0] r_g_rdata;
    logic [QW-1:0] r_q_rdata;

    // memory controls
    logic          g_we_flag;
    logic          g_we_dist;
    logic [AW-1:0] g_waddr;
    t_flags        g_wflags;
    logic [DW:0]   g_wdist;
    logic [AW-1:0] g_raddr;
    logic          q_we;
    logic [AW-1:0] q_waddr;
    logic [QW-1:0] q_wdata;
    logic [AW-1:0] q_raddr;

    // command side
    logic          accept;
    logic          in_phys;
    logic [AW-1:0] in_addr;
    t_flags        in_flags;

    // neighbour unit
    t_nbr_sel      nb_sel;
    logic [FX-1:0] nb_f_in;
    logic [RX-1:0] nb_r_in;
    logic [CX-1:0] nb_c_in;
    logic          nb_ok;
    logic [FW-1:0] nb_f;
    logic [RW-1:0] nb_r;
    logic [CW-1:0] nb_c;
    logic [AW-1:0] nb_addr;

    logic          sweep_last;
    logic          p_hit;
    logic [FW-1:0] q_f;
    logic [RW-1:0] q_r;
    logic [CW-1:0] q_c;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // physical store bounds only; configured size does not matter for writes and reads
    assign in_phys = (FX'(i_cell_floor) < FX'(MAX_FLOORS)) &&
                     (RX'(i_cell_row) < RX'(MAX_ROWS)) &&
                     (CX'(i_cell_col) < CX'(MAX_COLS));
    assign in_addr  = f_addr(FW'(i_cell_floor), RW'(i_cell_row), CW'(i_cell_col));
    assign in_flags = {i_has_stair_down, i_has_stair_up, i_is_wall};

    // idle: self check of the command cell; search: current frontier cell
    always_comb begin
        nb_sel.up = r_cur_up;
        nb_sel.dn = r_cur_dn;
        if (r_state == ST_IDLE) begin
            nb_sel.dir = NB_SELF;
            nb_f_in    = FX'(i_cell_floor);
            nb_r_in    = RX'(i_cell_row);
            nb_c_in    = CX'(i_cell_col);
        end else begin
            nb_sel.dir = r_k;
            nb_f_in    = FX'(r_cur_f);
            nb_r_in    = RX'(r_cur_r);
            nb_c_in    = CX'(r_cur_c);
        end
    end

    gbfs_nbr #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .MAX_FLOORS (MAX_FLOORS)
    ) u_nbr (
        .i_sel   (nb_sel),
        .i_f     (nb_f_in),
        .i_r     (nb_r_in),
        .i_c     (nb_c_in),
        .i_cfg_w (r_cfg_w),
        .i_cfg_h (r_cfg_h),
        .i_cfg_f (r_cfg_f),
        .o_ok    (nb_ok),
        .o_f     (nb_f),
        .o_r     (nb_r),
        .o_c     (nb_c)
    );

    assign nb_addr = f_addr(nb_f, nb_r, nb_c);

    assign sweep_last = (r_sweep == AW'(CELL_TOTAL - 1));
    // neighbour read last cycle found an open cell with no distance yet
    assign p_hit = r_p_valid && !r_g_rdata[WALL_BIT] && !r_g_rdata[VIS_BIT];

    assign {q_f, q_r, q_c} = r_q_rdata;

    always_comb begin
        n_state       = r_state;
        n_sweep       = r_sweep;
        n_sweep_cells = r_sweep_cells;
        n_head        = r_head;
        n_tail        = r_tail;
        n_k           = r_k;
        n_p_valid     = 1'b0;
        n_rd_pend     = 1'b0;
        n_out_valid   = 1'b0;
        n_out_kind    = r_out_kind;
        n_out_dist    = r_out_dist;

        g_we_flag = 1'b0;
        g_we_dist = 1'b0;
        g_waddr   = in_addr;
        g_wflags  = in_flags;
        g_wdist   = '0;
        g_raddr   = in_addr;
        q_we      = 1'b0;
        q_waddr   = r_tail[AW-1:0];
        q_wdata   = r_p_entry;
        q_raddr   = r_head[AW-1:0];

        // read answer, in the cycle after the grid read
        if (r_rd_pend) begin
            n_out_valid = 1'b1;
            n_out_kind  = KIND_READ;
            if (r_rd_phys && r_g_rdata[VIS_BIT]) begin
                n_out_dist = t_dist'(DIST_W'(r_g_rdata[DW-1:0]));
            end else begin
                n_out_dist = DIST_NONE;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_WRITE: begin
                            g_we_flag = in_phys;
                        end
                        OP_SEARCH: begin
                            n_state       = ST_SWEEP;
                            n_sweep       = '0;
                            n_sweep_cells = 1'b0;
                            n_head        = '0;
                            n_tail        = '0;
                        end
                        OP_READ: begin
                            n_rd_pend = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                // clear the distance lane, and the flags too after reset
                g_waddr   = r_sweep;
                g_we_dist = 1'b1;
                g_wdist   = '0;
                g_we_flag = r_sweep_cells;
                g_wflags  = FLAGS_RESET;
                n_sweep   = r_sweep + AW'(1);
                if (sweep_last) begin
                    n_sweep = '0;
                    n_state = r_sweep_cells ? ST_IDLE : ST_START;
                end
            end
            ST_START: begin
                g_raddr = r_st_addr;
                n_state = ST_START_CHK;
            end
            ST_START_CHK: begin
                if (r_st_ok && !r_g_rdata[WALL_BIT]) begin
                    g_we_dist = 1'b1;
                    g_waddr   = r_st_addr;
                    g_wdist   = {1'b1, DW'(0)};
                    q_we      = 1'b1;
                    q_waddr   = '0;
                    q_wdata   = r_st_entry;
                    n_head    = '0;
                    n_tail    = (AW + 1)'(1);
                    n_state   = ST_POP;
                end else begin
                    // wall or out-of-grid start: nothing reached
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_SEARCH;
                    n_out_dist  = DIST_NONE;
                    n_state     = ST_IDLE;
                end
            end
            ST_POP: begin
                if (r_head == r_tail) begin
                    // frontier empty; the start keeps distance zero
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_SEARCH;
                    n_out_dist  = '0;
                    n_state     = ST_IDLE;
                end else begin
                    q_raddr = r_head[AW-1:0];
                    n_head  = r_head + (AW + 1)'(1);
                    n_state = ST_CUR;
                end
            end
            ST_CUR: begin
                g_raddr = f_addr(q_f, q_r, q_c);
                n_state = ST_FLAGS;
            end
            ST_FLAGS: begin
                n_k     = NB_EAST;
                n_state = ST_NBR;
            end
            ST_NBR: begin
                // read neighbour k while settling neighbour k-1
                g_raddr   = nb_addr;
                n_p_valid = nb_ok;
                n_k       = r_k + 3'd1;
                if (r_k == NB_DOWN) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_POP;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // settle the pending neighbour: set its distance and push it
        if ((r_state == ST_NBR || r_state == ST_DRAIN) && p_hit) begin
            g_we_dist = 1'b1;
            g_waddr   = r_p_addr;
            g_wdist   = {1'b1, r_nd};
            q_we      = 1'b1;
            q_waddr   = r_tail[AW-1:0];
            q_wdata   = r_p_entry;
            n_tail    = r_tail + (AW + 1)'(1);
        end
    end

    // grid memory, flag lane and distance lane written separately
    always_ff @(posedge i_clk) begin
        if (g_we_flag) begin
            grid_mem[g_waddr][GE-1:FLAG_LO] <= g_wflags;
        end
        if (g_we_dist) begin
            grid_mem[g_waddr][DW:0] <= g_wdist;
        end
        r_g_rdata <= grid_mem[g_raddr];
    end

    // frontier queue memory
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            queue_mem[q_waddr] <= q_wdata;
        end
        r_q_rdata <= queue_mem[q_raddr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RST_WIDTH;
            r_cfg_h <= RST_HEIGHT;
            r_cfg_f <= RST_FLOORS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:  r_cfg_w <= i_cfg_wdata;
                CFG_HEIGHT: r_cfg_h <= i_cfg_wdata;
                CFG_FLOORS: r_cfg_f <= i_cfg_wdata[CFG_FLOOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // control registers; reset starts the full clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_SWEEP;
            r_sweep       <= '0;
            r_sweep_cells <= 1'b1;
            r_head        <= '0;
            r_tail        <= '0;
            r_k           <= NB_EAST;
            r_p_valid     <= 1'b0;
            r_rd_pend     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_sweep       <= n_sweep;
            r_sweep_cells <= n_sweep_cells;
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_k           <= n_k;
            r_p_valid     <= n_p_valid;
            r_rd_pend     <= n_rd_pend;
            r_out_valid   <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_dist <= n_out_dist;
        r_rd_phys  <= in_phys;
        if (accept && i_op == OP_SEARCH) begin
            r_st_ok    <= nb_ok;
            r_st_addr  <= nb_addr;
            r_st_entry <= {nb_f, nb_r, nb_c};
        end
        if (r_state == ST_CUR) begin
            r_cur_f <= q_f;
            r_cur_r <= q_r;
            r_cur_c <= q_c;
        end
        if (r_state == ST_FLAGS) begin
            r_cur_up <= r_g_rdata[UP_BIT];
            r_cur_dn <= r_g_rdata[DN_BIT];
            r_nd     <= r_g_rdata[DW-1:0] + DW'(1);
        end
        if (r_state == ST_NBR) begin
            r_p_addr  <= nb_addr;
            r_p_entry <= {nb_f, nb_r, nb_c};
        end
    end

    assign o_valid      = r_out_valid;
    assign o_reply_kind = r_out_kind;
    assign o_distance   = r_out_dist;

endmodule
